// ----- rtl/lirgr_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, result and register codes, and controller/datapath handoff types.
package lirgr_pkg;

  localparam int SAMPLE_BITS           = 16;
  localparam int MAX_OUTPUTS_PER_FRAME = 16;
  localparam int CNT_W = (MAX_OUTPUTS_PER_FRAME > 1) ? $clog2(MAX_OUTPUTS_PER_FRAME) : 1;

  localparam int PHASE_W    = 20;
  localparam int GAIN_W     = 16;
  localparam int SCALE_W    = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [KIND_W-1:0] KIND_FRAME   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GAIN    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE        = 2'd2;

  localparam logic [PHASE_W-1:0] PHASE_ONE      = 20'h10000;
  localparam logic [PHASE_W-1:0] PHASE_MAX      = 20'hFFFFF;
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 20'h10000;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 16'h8000;

  localparam logic [GAIN_W-1:0] GAIN_ONE   = 16'd32768;
  localparam logic [GAIN_W-1:0] STEP_MAX   = 16'd1638;
  localparam logic [GAIN_W-1:0] SILENT_MAX = 16'd3;

  typedef struct packed {
    logic load_item;
    logic prime;
    logic tick;
    logic refuse;
    logic frame;
    logic lin;
    logic mlo;
    logic mhi;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic refuse;
    logic prime_empty;
    logic emit_more;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/lirgr_src_if.sv -----
`timescale 1ns / 1ps
// Input item channel: source frames and gain ticks.
interface lirgr_src_if;
  import lirgr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic [GAIN_W-1:0]             target_gain;
  logic [GAIN_W-1:0]             elapsed_step;
  logic                          smooth;
  logic                          rewind_when_silent;
  logic                          immediate;

  modport source (
    output valid, func, left_in, right_in, target_gain, elapsed_step, smooth,
           rewind_when_silent, immediate,
    input  ready
  );

  modport sink (
    input  valid, func, left_in, right_in, target_gain, elapsed_step, smooth,
           rewind_when_silent, immediate,
    output ready
  );
endinterface

// ----- rtl/lirgr_res_if.sv -----
`timescale 1ns / 1ps
// Result item channel: output frames, refusals and gain status.
interface lirgr_res_if;
  import lirgr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [KIND_W-1:0]             kind;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          last_of_run;
  logic                          seek_request;
  logic [GAIN_W-1:0]             gain_now;

  modport source (
    output valid, kind, left_out, right_out, last_of_run, seek_request, gain_now,
    input  ready
  );

  modport sink (
    input  valid, kind, left_out, right_out, last_of_run, seek_request, gain_now,
    output ready
  );
endinterface

// ----- rtl/lirgr_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
interface lirgr_cfg_if;
  import lirgr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- rtl/lirgr_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer that steps the datapath through ticks, refusals, priming and output frames.
module lirgr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lirgr_pkg::dp_stat_t stat,
  output lirgr_pkg::dp_cmd_t  cmd
);
  import lirgr_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_DECODE = 10'b00_0000_0010,
    ST_TICK   = 10'b00_0000_0100,
    ST_REFUSE = 10'b00_0000_1000,
    ST_FRAME  = 10'b00_0001_0000,
    ST_CHECK  = 10'b00_0010_0000,
    ST_LIN    = 10'b00_0100_0000,
    ST_MLO    = 10'b00_1000_0000,
    ST_MHI    = 10'b01_0000_0000,
    ST_EMIT   = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.is_tick) begin
          state_next = ST_TICK;
        end else if (stat.refuse) begin
          state_next = ST_REFUSE;
        end else if (stat.prime_empty) begin
          // first frame only fills the older slot
          cmd.prime  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_FRAME;
        end
      end
      ST_TICK: begin
        if (stat.out_free) begin
          cmd.tick   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_REFUSE: begin
        if (stat.out_free) begin
          cmd.refuse = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FRAME: begin
        cmd.frame  = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = stat.emit_more ? ST_LIN : ST_IDLE;
      end
      ST_LIN: begin
        cmd.lin    = 1'b1;
        state_next = ST_MLO;
      end
      ST_MLO: begin
        cmd.mlo    = 1'b1;
        state_next = ST_MHI;
      end
      ST_MHI: begin
        cmd.mhi    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // hold the rounded beat until the output register frees up
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.last ? ST_IDLE : ST_LIN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lirgr_dp.sv -----
`timescale 1ns / 1ps
// Datapath: item latch, frame history, phase, gain ramp, per-lane interpolation and result register.
module lirgr_dp (
  input  logic                                      clk,
  input  logic                                      rst,
  input  lirgr_pkg::dp_cmd_t                        cmd,
  output lirgr_pkg::dp_stat_t                       stat,
  input  logic                                      func,
  input  logic signed [lirgr_pkg::SAMPLE_BITS-1:0]  left_in,
  input  logic signed [lirgr_pkg::SAMPLE_BITS-1:0]  right_in,
  input  logic [lirgr_pkg::GAIN_W-1:0]              target_gain,
  input  logic [lirgr_pkg::GAIN_W-1:0]              elapsed_step,
  input  logic                                      smooth,
  input  logic                                      rewind_when_silent,
  input  logic                                      immediate,
  lirgr_cfg_if.sink                                 cfg,
  lirgr_res_if.source                               res
);
  import lirgr_pkg::*;

  localparam int S      = SAMPLE_BITS;
  localparam int GS_W   = GAIN_W + SCALE_W;
  localparam int HALF   = GS_W / 2;
  localparam int LIN_W  = S + 19;
  localparam int MUL_W  = LIN_W + HALF + 1;
  localparam int ACC_W  = LIN_W + GS_W + 1;
  localparam int RND_SH = 46;
  localparam int R_W    = ACC_W - RND_SH;

  localparam logic signed [ACC_W-1:0] RND_HALF =
    {{(ACC_W - RND_SH){1'b0}}, 1'b1, {(RND_SH - 1){1'b0}}};
  localparam logic signed [R_W-1:0] SAT_HI = {{(R_W - S + 1){1'b0}}, {(S - 1){1'b1}}};
  localparam logic signed [R_W-1:0] SAT_LO = {{(R_W - S + 1){1'b1}}, {(S - 1){1'b0}}};

  // latched item
  logic                it_func;
  logic signed [S-1:0] it_smp [2];
  logic [GAIN_W-1:0]   it_target;
  logic [GAIN_W-1:0]   it_step;
  logic                it_smooth;
  logic                it_rewind;
  logic                it_imm;

  // configuration
  logic [PHASE_W-1:0] phase_step;
  logic [SCALE_W-1:0] output_scale;
  logic               pause_when_silent;

  // block state
  logic signed [S-1:0] older [2];
  logic signed [S-1:0] newer [2];
  logic [PHASE_W-1:0]  phase;
  logic [GAIN_W-1:0]   ramp_gain;
  logic                started;
  logic [1:0]          prime_count;
  logic [CNT_W-1:0]    out_cnt;
  logic [GS_W-1:0]     gs;
  logic signed [LIN_W-1:0] lin [2];
  logic signed [ACC_W-1:0] acc [2];

  // result register
  logic                r_valid;
  logic [KIND_W-1:0]   r_kind;
  logic signed [S-1:0] r_smp [2];
  logic                r_last;
  logic                r_seek;
  logic [GAIN_W-1:0]   r_gain;

  function automatic logic signed [S-1:0] round_sat(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] t;
    logic signed [R_W-1:0]   q;
    t = p + RND_HALF;
    q = t[ACC_W-1:RND_SH];
    if (q > SAT_HI) begin
      round_sat = SAT_HI[S-1:0];
    end else if (q < SAT_LO) begin
      round_sat = SAT_LO[S-1:0];
    end else begin
      round_sat = q[S-1:0];
    end
  endfunction

  // gain tick
  logic [GAIN_W-1:0]         tgt_c;
  logic [GAIN_W-1:0]         stp_c;
  logic signed [GAIN_W+1:0]  gdiff;
  logic signed [GAIN_W+1:0]  gstep;
  logic [GAIN_W:0]           gup;
  logic [GAIN_W-1:0]         gain_new;
  logic                      started_new;
  logic                      rewind_hit;

  always_comb begin
    tgt_c = (it_target > GAIN_ONE) ? GAIN_ONE : it_target;
    stp_c = (it_step > STEP_MAX) ? STEP_MAX : it_step;
    gdiff = signed'({2'b00, tgt_c}) - signed'({2'b00, ramp_gain});
    gstep = signed'({2'b00, stp_c});
    gup   = {1'b0, ramp_gain} + {1'b0, stp_c};
    if (it_imm) begin
      gain_new = tgt_c;
    end else if (it_smooth) begin
      if (gdiff > gstep) begin
        gain_new = ramp_gain + stp_c;
      end else if (gdiff < -gstep) begin
        gain_new = ramp_gain - stp_c;
      end else begin
        gain_new = tgt_c;
      end
    end else begin
      // rise-limited: rises no faster than the step; a lower target is taken at once
      gain_new = ({1'b0, tgt_c} < gup) ? tgt_c : gup[GAIN_W-1:0];
    end
    started_new = started | (tgt_c != '0);
    rewind_hit  = it_rewind && (tgt_c == '0) && (gain_new <= SILENT_MAX) && started_new;
  end

  // phase bookkeeping
  logic [PHASE_W-1:0] phase_dec;
  logic [PHASE_W:0]   phase_sum;
  logic [PHASE_W-1:0] phase_adv;
  logic               cap;
  logic               last_c;

  always_comb begin
    phase_dec = (phase >= PHASE_ONE) ? (phase - PHASE_ONE) : '0;
    phase_sum = {1'b0, phase} + {1'b0, phase_step};
    phase_adv = (phase_sum > {1'b0, PHASE_MAX}) ? PHASE_MAX : phase_sum[PHASE_W-1:0];
    cap       = (out_cnt == CNT_W'(MAX_OUTPUTS_PER_FRAME - 1));
    last_c    = (phase_adv >= PHASE_ONE) || cap;
  end

  // per-lane arithmetic
  logic signed [16:0]      frac;
  logic signed [HALF:0]    gs_lo;
  logic signed [HALF:0]    gs_hi;
  logic signed [S:0]       dlt [2];
  logic signed [S+17:0]    dfr [2];
  logic signed [LIN_W-1:0] lin_c [2];
  logic signed [MUL_W-1:0] mlo_c [2];
  logic signed [MUL_W-1:0] mhi_c [2];
  logic signed [S-1:0]     smp_c [2];
  logic [GS_W-1:0]         gs_c;

  always_comb begin
    frac  = signed'({1'b0, phase[15:0]});
    gs_lo = signed'({1'b0, gs[HALF-1:0]});
    gs_hi = signed'({1'b0, gs[GS_W-1:HALF]});
    gs_c  = {{SCALE_W{1'b0}}, ramp_gain} * {{GAIN_W{1'b0}}, output_scale};
    for (int i = 0; i < 2; i++) begin
      dlt[i]   = signed'({newer[i][S-1], newer[i]}) - signed'({older[i][S-1], older[i]});
      dfr[i]   = dlt[i] * frac;
      lin_c[i] = signed'({{3{older[i][S-1]}}, older[i], 16'b0})
               + signed'({dfr[i][S+17], dfr[i]});
      mlo_c[i] = lin[i] * gs_lo;
      mhi_c[i] = lin[i] * gs_hi;
      smp_c[i] = round_sat(acc[i]);
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step        <= PHASE_STEP_RST;
      output_scale      <= SCALE_RST;
      pause_when_silent <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PHASE_STEP:   phase_step        <= cfg.data[PHASE_W-1:0];
        CFG_OUTPUT_SCALE: output_scale      <= cfg.data[SCALE_W-1:0];
        CFG_PAUSE:        pause_when_silent <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  // item latch and arithmetic pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_func   <= func;
      it_smp[0] <= left_in;
      it_smp[1] <= right_in;
      it_target <= target_gain;
      it_step   <= elapsed_step;
      it_smooth <= smooth;
      it_rewind <= rewind_when_silent;
      it_imm    <= immediate;
    end
    if (cmd.frame) begin
      gs <= gs_c;
    end
    for (int i = 0; i < 2; i++) begin
      if (cmd.lin) begin
        lin[i] <= lin_c[i];
      end
      if (cmd.mlo) begin
        acc[i] <= signed'({{(ACC_W - MUL_W){mlo_c[i][MUL_W-1]}}, mlo_c[i]});
      end else if (cmd.mhi) begin
        acc[i] <= acc[i] + signed'({mhi_c[i], {HALF{1'b0}}});
      end
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        older[i] <= '0;
        newer[i] <= '0;
      end
      phase       <= '0;
      ramp_gain   <= '0;
      started     <= 1'b0;
      prime_count <= '0;
      out_cnt     <= '0;
    end else begin
      if (cmd.tick) begin
        ramp_gain <= gain_new;
        if (rewind_hit) begin
          started     <= 1'b0;
          prime_count <= '0;
          phase       <= '0;
        end else begin
          started <= started_new;
        end
      end
      if (cmd.prime) begin
        older       <= it_smp;
        prime_count <= 2'd1;
      end
      if (cmd.frame) begin
        out_cnt <= '0;
        if (prime_count == 2'd1) begin
          newer       <= it_smp;
          prime_count <= 2'd2;
        end else begin
          older <= newer;
          newer <= it_smp;
          phase <= phase_dec;
        end
      end
      if (cmd.emit) begin
        out_cnt <= out_cnt + CNT_W'(1);
        // cap reached below one: drop the rest and park the phase at one
        phase   <= (cap && (phase_adv < PHASE_ONE)) ? PHASE_ONE : phase_adv;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (cmd.tick || cmd.refuse || cmd.emit) begin
      r_valid <= 1'b1;
    end else if (res.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      r_kind   <= KIND_GAIN;
      r_smp[0] <= '0;
      r_smp[1] <= '0;
      r_last   <= 1'b1;
      r_seek   <= rewind_hit;
      r_gain   <= gain_new;
    end else if (cmd.refuse) begin
      r_kind   <= KIND_REFUSED;
      r_smp[0] <= '0;
      r_smp[1] <= '0;
      r_last   <= 1'b1;
      r_seek   <= 1'b0;
      r_gain   <= ramp_gain;
    end else if (cmd.emit) begin
      r_kind   <= KIND_FRAME;
      r_smp    <= smp_c;
      r_last   <= last_c;
      r_seek   <= 1'b0;
      r_gain   <= ramp_gain;
    end
  end

  assign res.valid        = r_valid;
  assign res.kind         = r_kind;
  assign res.left_out     = r_smp[0];
  assign res.right_out    = r_smp[1];
  assign res.last_of_run  = r_last;
  assign res.seek_request = r_seek;
  assign res.gain_now     = r_gain;

  always_comb begin
    stat.is_tick     = it_func;
    stat.refuse      = !started || (phase_step == '0)
                     || (pause_when_silent && (ramp_gain <= SILENT_MAX));
    stat.prime_empty = (prime_count == 2'd0);
    stat.emit_more   = (phase < PHASE_ONE);
    stat.last        = last_c;
    stat.out_free    = !r_valid || res.ready;
  end

endmodule

// ----- rtl/linear_interp_resampler_gain_ramp.sv -----
`timescale 1ns / 1ps
// Top level of the stereo linear-interpolation resampler with ramped gain.
//
// Takes one item at a time on src: a Q1.15 stereo source frame or a gain tick. A tick
// moves the gain (immediate, symmetric slew or rise-limited slew) and returns one gain
// status beat. A refused frame returns one refusal beat; the first frame that is not
// refused after a rewind or reset only primes and returns nothing. Any other frame
// returns n output beats (n up to 16), with both lanes sharing one sequence through the
// blend multiply, the two halves of the gain product and the rounding stage; a full
// result register or a slow sink stalls it. Configuration writes are taken at any time
// and are meant for idle periods.
module linear_interp_resampler_gain_ramp (
  input  logic        clk,
  input  logic        rst,
  lirgr_src_if.sink   src,
  lirgr_res_if.source res,
  lirgr_cfg_if.sink   cfg
);
  import lirgr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign src.ready = in_ready;

  lirgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (src.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lirgr_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .func               (src.func),
    .left_in            (src.left_in),
    .right_in           (src.right_in),
    .target_gain        (src.target_gain),
    .elapsed_step       (src.elapsed_step),
    .smooth             (src.smooth),
    .rewind_when_silent (src.rewind_when_silent),
    .immediate          (src.immediate),
    .cfg                (cfg),
    .res                (res)
  );

endmodule
